[rtl/core/slwm_pkg.sv]
package slwm_pkg;

  localparam int unsigned WindowMaxDefault = 64;

  localparam int ScoreW = 32;
  localparam int WlenW  = 7;
  localparam int BarW   = 12;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  // product (hi - cur) * bar_height
  localparam int NumW = ScoreW + BarW;

  localparam logic [WlenW-1:0] WlenReset = WlenW'(64);
  localparam logic [BarW-1:0]  BarReset  = BarW'(400);

  // register index = paddr[2]
  typedef enum logic {
    REG_WLEN = 1'b0,
    REG_BAR  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [ScoreW-1:0] above;
    logic [ScoreW-1:0] span;
    logic [BarW-1:0]   bar;
  } scale_req_t;

  typedef struct packed {
    logic            done;
    logic [BarW-1:0] offset;
  } scale_rsp_t;

endpackage

[rtl/core/slwm_scale.sv]
module slwm_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slwm_pkg::scale_req_t req_i,
  output slwm_pkg::scale_rsp_t rsp_o
);
  import slwm_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [ScoreW-1:0] den_q, den_d;
  logic [ScoreW-1:0] rem_q, rem_d;
  logic [BarW-1:0]   quo_q, quo_d;

  logic [ScoreW:0]   trial;
  logic [ScoreW:0]   diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      num_d  = NumW'(req_i.above * req_i.bar);
      den_d  = req_i.span;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[ScoreW-1:0] : trial[ScoreW-1:0];
      num_d = {num_q[NumW-2:0], 1'b0};
      quo_d = {quo_q[BarW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.offset = quo_q;

endmodule

[rtl/core/sliding_window_level_meter_core.sv]
// Sliding-window level meter.
// Input channel (in_valid_i / in_stall_o): one item per score_i, or clear_i
// high to empty the window. Output channel (out_valid_o / out_stall_i): one
// item per input item with window min/max, flat flag, bar offset and the
// below-half flag. An item is taken at a clock edge with valid high and
// stall low.
// Flow, from the edge that takes an item to the edge that loads its result:
// a clear goes straight to the done state. A score walks the ring entries
// of the active window (up to WINDOW_MAX deep) through the single read
// port of the sample memory, does the last compare, then multiplies,
// starts and runs the bit-serial divider, picks up the quotient and loads
// the output. A flat window skips the divider.
// One item is in work at a time; the input stalls until the result is loaded
// and the next item can be taken in the next cycle. A result that finds the
// previous one still stalled in the output register waits, and so does the
// input. A stalled result holds in the output register until taken.
// Reset empties the window, zeroes the write pointer, sets window_length to
// 64 and bar_height to 400. The ring memory is not cleared; only entries
// already written are ever read. Configure over APB while idle only.
module sliding_window_level_meter_core #(
  parameter int unsigned WINDOW_MAX = slwm_pkg::WindowMaxDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slwm_pkg::AddrW-1:0]  paddr,
  input  logic [slwm_pkg::DataW-1:0]  pwdata,
  output logic [slwm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [slwm_pkg::ScoreW-1:0] score_i,
  input  logic                        clear_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        window_valid_o,
  output logic [slwm_pkg::ScoreW-1:0] window_min_o,
  output logic [slwm_pkg::ScoreW-1:0] window_max_o,
  output logic                        flat_o,
  output logic [slwm_pkg::BarW-1:0]   level_offset_o,
  output logic                        below_half_o
);
  import slwm_pkg::*;

  localparam int PtrW = $clog2(WINDOW_MAX);
  localparam int CntW = $clog2(WINDOW_MAX + 1);
  localparam int EW   = (CntW > WlenW) ? CntW : WlenW;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_MAX - 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(WINDOW_MAX);
  localparam logic [EW-1:0]   EwMax   = EW'(WINDOW_MAX);

  // ---------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------
  logic [WlenW-1:0] wlen_q;
  logic [BarW-1:0]  bar_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WlenReset;
      bar_q  <= BarReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WLEN: wlen_q <= pwdata[WlenW-1:0];
        REG_BAR:  bar_q  <= pwdata[BarW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WLEN: prdata = DataW'(wlen_q);
      REG_BAR:  prdata = DataW'(bar_q);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  state_e            state_q, state_d;
  logic [PtrW-1:0]   wp_q;
  logic [CntW-1:0]   fill_q;
  logic [CntW-1:0]   rem_q;
  logic              pend_q;
  logic              clr_q;
  logic              out_valid_q;

  logic [PtrW-1:0]   rd_idx_q;
  logic [ScoreW-1:0] rd_data_q;
  logic [ScoreW-1:0] cur_q, lo_q, hi_q;
  logic [BarW-1:0]   off_q;

  logic              accept;
  logic              out_free;
  logic              scan_done;
  logic              flat_now;
  logic              out_load;

  logic [CntW-1:0]   fill_nx;
  logic [EW-1:0]     wl_ext, wl_eff, fill_ext, n_eff;

  scale_req_t        req;
  scale_rsp_t        rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign scan_done  = (state_q == ST_SCAN) && (rem_q == '0) && !pend_q;
  assign flat_now   = (hi_q == lo_q);

  // active depth: window_length clamped to 1..WINDOW_MAX, then to fill
  always_comb begin
    fill_nx  = (fill_q != CntMax) ? fill_q + CntW'(1) : fill_q;
    wl_ext   = EW'(wlen_q);
    wl_eff   = (wl_ext == '0) ? EW'(1) : wl_ext;
    if (wl_eff > EwMax) wl_eff = EwMax;
    fill_ext = EW'(fill_nx);
    n_eff    = (wl_eff > fill_ext) ? fill_ext : wl_eff;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = clear_i ? ST_DONE : ST_SCAN;
      ST_SCAN: if (scan_done) state_d = flat_now ? ST_DONE : ST_DIV;
      ST_DIV:  if (rsp.done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req.start = scan_done && !flat_now;
    req.above = hi_q - cur_q;
    req.span  = hi_q - lo_q;
    req.bar   = bar_q;
    out_load  = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == ST_SCAN) && (rem_q != '0);
      if (accept) begin
        clr_q <= clear_i;
        if (clear_i) begin
          fill_q <= '0;
          rem_q  <= '0;
        end else begin
          wp_q   <= (wp_q == PtrLast) ? '0 : wp_q + PtrW'(1);
          fill_q <= fill_nx;
          rem_q  <= CntW'(n_eff - EW'(1));
        end
      end else if ((state_q == ST_SCAN) && (rem_q != '0)) begin
        rem_q <= rem_q - CntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sample ring: one write port, one registered read port
  // ---------------------------------------------------------------
  logic [ScoreW-1:0] ring_mem [WINDOW_MAX];

  always_ff @(posedge clk_i) begin
    if (accept && !clear_i) begin
      ring_mem[wp_q] <= score_i;
    end
    rd_data_q <= ring_mem[rd_idx_q];
  end

  // scan walks backward from the entry before the newest one
  always_ff @(posedge clk_i) begin
    if (accept && !clear_i) begin
      cur_q    <= score_i;
      lo_q     <= score_i;
      hi_q     <= score_i;
      rd_idx_q <= (wp_q == '0) ? PtrLast : wp_q - PtrW'(1);
    end else begin
      if ((state_q == ST_SCAN) && (rem_q != '0)) begin
        rd_idx_q <= (rd_idx_q == '0) ? PtrLast : rd_idx_q - PtrW'(1);
      end
      if (pend_q) begin
        if (rd_data_q < lo_q) lo_q <= rd_data_q;
        if (rd_data_q > hi_q) hi_q <= rd_data_q;
      end
    end
    if (scan_done && flat_now) begin
      off_q <= bar_q >> 1;
    end else if (rsp.done) begin
      off_q <= rsp.offset;
    end
  end

  slwm_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (clr_q) begin
        window_valid_o <= 1'b0;
        window_min_o   <= '0;
        window_max_o   <= '0;
        flat_o         <= 1'b0;
        level_offset_o <= '0;
        below_half_o   <= 1'b0;
      end else begin
        window_valid_o <= 1'b1;
        window_min_o   <= lo_q;
        window_max_o   <= hi_q;
        flat_o         <= flat_now;
        level_offset_o <= off_q;
        // 2*(cur - lo) < (hi - lo); false when flat
        below_half_o   <= ({cur_q - lo_q, 1'b0} < {1'b0, hi_q - lo_q});
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/slwm_checker.sv]
module slwm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        window_valid_o,
  input logic [slwm_pkg::ScoreW-1:0] window_min_o,
  input logic [slwm_pkg::ScoreW-1:0] window_max_o,
  input logic                        flat_o,
  input logic [slwm_pkg::BarW-1:0]   level_offset_o,
  input logic                        below_half_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_min_o)
      && $stable(window_max_o) && $stable(level_offset_o))
    else $error("stalled result changed");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_valid_o |-> window_min_o == '0 && window_max_o == '0
      && !flat_o && level_offset_o == '0 && !below_half_o)
    else $error("empty window result not zero");

  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_valid_o && flat_o |->
      window_min_o == window_max_o && !below_half_o)
    else $error("flat result inconsistent");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_valid_o && !flat_o |-> window_min_o < window_max_o)
    else $error("min not below max");

endmodule

bind sliding_window_level_meter_core slwm_checker u_slwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .window_valid_o (window_valid_o),
  .window_min_o   (window_min_o),
  .window_max_o   (window_max_o),
  .flat_o         (flat_o),
  .level_offset_o (level_offset_o),
  .below_half_o   (below_half_o)
);

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slwm_pkg::*;

  // ring depth of the instance (default parameter)
  localparam int unsigned RingDepth = WindowMaxDefault;
  // cycles without any handshake before the run is abandoned; the slowest
  // item walks the whole ring and the divider, plus a long random stall
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ItemsPerPhase = 135;
  localparam int unsigned NumPhases = 8;

  typedef struct {
    logic [ScoreW-1:0] score;
    logic              clr;
  } score_item_t;

  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] lo;
    logic [ScoreW-1:0] hi;
    logic              flat;
    logic [BarW-1:0]   offset;
    logic              below;
  } level_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ScoreW-1:0] score_i = '0;
  logic              clear_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              window_valid_o;
  logic [ScoreW-1:0] window_min_o;
  logic [ScoreW-1:0] window_max_o;
  logic              flat_o;
  logic [BarW-1:0]   level_offset_o;
  logic              below_half_o;

  sliding_window_level_meter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .score_i        (score_i),
    .clear_i        (clear_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_valid_o (window_valid_o),
    .window_min_o   (window_min_o),
    .window_max_o   (window_max_o),
    .flat_o         (flat_o),
    .level_offset_o (level_offset_o),
    .below_half_o   (below_half_o)
  );

  // items waiting for the driver, levels waiting for the monitor
  score_item_t pending_scores[$];
  level_t      expected_levels[$];

  // shadow of the meter: ring, pointers and the two registers
  logic [ScoreW-1:0] ring_shadow [RingDepth];
  int unsigned       wr_ptr;
  int unsigned       fill_cnt;
  logic [WlenW-1:0]  cfg_wlen;
  logic [BarW-1:0]   cfg_bar;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic [ScoreW-1:0] last_score = '0;
  logic [ScoreW-1:0] near_base = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Push one score (or a clear) through the shadow and return the level
  // the meter must report for it.
  function automatic level_t predict_level(input logic [ScoreW-1:0] score, input logic clr);
    level_t            lvl;
    int unsigned       depth;
    int unsigned       idx;
    logic [ScoreW-1:0] v;
    logic [63:0]       span;
    logic [63:0]       above;
    logic [63:0]       off;
    lvl = '0;
    if (clr) begin
      fill_cnt = 0;
      return lvl;
    end
    ring_shadow[wr_ptr] = score;
    idx = wr_ptr;
    wr_ptr = (wr_ptr + 1 >= RingDepth) ? 0 : wr_ptr + 1;
    if (fill_cnt < RingDepth) fill_cnt++;
    // zero length acts as one, oversize saturates at the ring depth
    depth = cfg_wlen;
    if (depth == 0) depth = 1;
    if (depth > RingDepth) depth = RingDepth;
    if (depth > fill_cnt) depth = fill_cnt;
    lvl.valid = 1'b1;
    lvl.lo = score;
    lvl.hi = score;
    for (int unsigned i = 1; i < depth; i++) begin
      idx = (idx == 0) ? RingDepth - 1 : idx - 1;
      v = ring_shadow[idx];
      if (v < lvl.lo) lvl.lo = v;
      if (v > lvl.hi) lvl.hi = v;
    end
    if (lvl.hi == lvl.lo) begin
      // flat window: bar middle, never below half
      lvl.flat = 1'b1;
      lvl.offset = cfg_bar >> 1;
    end else begin
      span = 64'(lvl.hi) - 64'(lvl.lo);
      above = 64'(lvl.hi) - 64'(score);
      off = (above * 64'(cfg_bar)) / span;
      lvl.offset = off[BarW-1:0];
      lvl.below = ((64'(score) - 64'(lvl.lo)) * 2 < span);
    end
    return lvl;
  endfunction

  // Driver: keeps in_valid_i up across back-to-back items, holds the
  // payload while stalled and idles at random per send_idle_pct.
  always @(posedge clk_i) begin : drive_scores
    score_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_levels.insert(expected_levels.size(), predict_level(score_i, clear_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_scores.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_scores[0];
          pending_scores.delete(0);
          in_valid_i <= 1'b1;
          score_i <= nxt.score;
          clear_i <= nxt.clr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [ScoreW-1:0] want,
                             input logic [ScoreW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_cnt++;
    end
  endtask

  // Monitor: random stall, compare each taken result with the oldest level.
  always @(posedge clk_i) begin : watch_levels
    level_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual min %h max %h", $time,
                   window_min_o, window_max_o);
          mismatch_cnt++;
        end else begin
          want = expected_levels[0];
          expected_levels.delete(0);
          check_field("window_valid", 32'(want.valid), 32'(window_valid_o));
          check_field("window_min", want.lo, window_min_o);
          check_field("window_max", want.hi, window_max_o);
          check_field("flat", 32'(want.flat), 32'(flat_o));
          check_field("level_offset", 32'(want.offset), 32'(level_offset_o));
          check_field("below_half", 32'(want.below), 32'(below_half_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // APB write: setup, then access; the register takes the value at the
  // edge that ends the access cycle.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WLEN) cfg_wlen = val[WlenW-1:0];
    else cfg_bar = val[BarW-1:0];
  endtask

  task automatic push_item(input logic [ScoreW-1:0] score, input logic clr);
    score_item_t it;
    it.score = score;
    it.clr = clr;
    pending_scores.insert(pending_scores.size(), it);
  endtask

  // Random scores: mostly long runs so the window fills, with a mix of
  // wide-range, clustered, extreme and repeated values; clears are rare.
  task automatic push_random(input int unsigned count);
    logic [ScoreW-1:0] s;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: s = $urandom();
        4, 5:       s = near_base + $urandom_range(255);
        6:          s = $urandom_range(1) ? '1 : '0;
        7:          s = last_score;
        default:    s = {near_base[31:16], 16'($urandom())};
      endcase
      last_score = s;
      push_item(s, $urandom_range(99) < 3);
    end
  endtask

  // Wait until the meter has nothing queued, in flight or unreported.
  task automatic drain();
    while (pending_scores.size() != 0 || in_valid_i || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  logic [WlenW-1:0] phase_wlen [NumPhases] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd3, 7'd0, 7'd64};
  logic [BarW-1:0]  phase_bar  [NumPhases] = '{12'd40, 12'd4095, 12'd0, 12'd400, 12'd4095,
                                               12'd1, 12'd0, 12'd40};

  initial begin
    wr_ptr = 0;
    fill_cnt = 0;
    cfg_wlen = WlenReset;
    cfg_bar = BarReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: clear on an empty window, single
    // score (flat), full-scale range with the newest at top and bottom,
    // values around mid range, a flat pair, small spreads, a clear, then wide values.
    push_item('0, 1'b1);
    push_item('0, 1'b0);
    push_item('1, 1'b0);
    push_item('0, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0001, 1'b0);
    push_item(32'hFFFF_FFFE, 1'b0);
    push_item('0, 1'b1);
    push_item(32'd5, 1'b0);
    push_item(32'd5, 1'b0);
    push_item(32'd6, 1'b0);
    push_item(32'd4, 1'b0);
    push_item(32'd5, 1'b1);
    push_item(32'd1, 1'b0);
    push_item('1, 1'b0);
    push_item(32'h0001_0000, 1'b0);
    push_item(32'h0000_FFFF, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b0);
    push_item(32'h5555_5555, 1'b0);
    drain();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      // phase 6 takes random settings, the rest walk the extremes; going
      // from a long window to a short one exercises the shrink case
      if (p == 6) begin
        write_reg(REG_WLEN, DataW'($urandom_range(127)));
        write_reg(REG_BAR, DataW'($urandom_range(4095)));
      end else begin
        write_reg(REG_WLEN, DataW'(phase_wlen[p]));
        write_reg(REG_BAR, DataW'(phase_bar[p]));
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 73; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 73; end
        default: begin send_idle_pct = 21; recv_idle_pct = 21; end
      endcase
      near_base = $urandom();
      push_random(ItemsPerPhase / 2);
      // hold the sender until every result of the first half is back
      drain();
      push_random(ItemsPerPhase - ItemsPerPhase / 2);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
